/* design/scu_pkg.sv */
// shared constants and types for the spherical camera update core
package scu_pkg;

  // fixed-point format of vectors, lengths and angles
  localparam int FRAC    = 16;
  localparam int ANGLE_W = FRAC + 3;
  localparam int UP_W    = FRAC + 2;
  localparam int WORK    = 30;
  localparam int ITERS   = 16;

  // angle constants in Q2.30
  localparam logic signed [33:0] PI_W      = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_W = 34'sd1686629713;
  localparam logic signed [33:0] GAIN_W    = 34'sd652032874;

  // pi and pi/6 in the angle format, rounded half up
  localparam logic signed [ANGLE_W-1:0] PI_F    = ANGLE_W'(205887);
  localparam logic signed [ANGLE_W-1:0] SIXTH_F = ANGLE_W'(34315);

  // direction codes
  localparam logic [2:0] DIR_NONE  = 3'd0;
  localparam logic [2:0] DIR_FWD   = 3'd1;
  localparam logic [2:0] DIR_BACK  = 3'd2;
  localparam logic [2:0] DIR_LEFT  = 3'd3;
  localparam logic [2:0] DIR_RIGHT = 3'd4;

  // register indexes
  localparam logic REG_RADIUS = 1'b0;
  localparam logic REG_SPEED  = 1'b1;

  // cordic arctangent table, Q2.30
  function automatic logic signed [33:0] atan_at(input logic [4:0] i);
    unique case (i)
      5'd0:  atan_at = 34'sd843314857;
      5'd1:  atan_at = 34'sd497837829;
      5'd2:  atan_at = 34'sd263043837;
      5'd3:  atan_at = 34'sd133525159;
      5'd4:  atan_at = 34'sd67021687;
      5'd5:  atan_at = 34'sd33543516;
      5'd6:  atan_at = 34'sd16775851;
      5'd7:  atan_at = 34'sd8388437;
      5'd8:  atan_at = 34'sd4194283;
      5'd9:  atan_at = 34'sd2097149;
      5'd10: atan_at = 34'sd1048576;
      5'd11: atan_at = 34'sd524288;
      5'd12: atan_at = 34'sd262144;
      5'd13: atan_at = 34'sd131072;
      5'd14: atan_at = 34'sd65536;
      5'd15: atan_at = 34'sd32768;
      5'd16: atan_at = 34'sd16384;
      5'd17: atan_at = 34'sd8192;
      5'd18: atan_at = 34'sd4096;
      5'd19: atan_at = 34'sd2048;
      5'd20: atan_at = 34'sd1024;
      5'd21: atan_at = 34'sd512;
      5'd22: atan_at = 34'sd256;
      5'd23: atan_at = 34'sd128;
      default: atan_at = 34'sd0;
    endcase
  endfunction

endpackage

/* design/spherical_camera_update_core.sv */
// top level of the spherical camera update core
// Each input beat (a turn or a move) is worked through by a small sequencer
// around one shared CORDIC stage and one shared 34x34 multiply/round unit,
// and then one output beat carries position, look-at point and up vector.
// A turn runs the two CORDIC passes, each a setup step, 16 rotation steps
// and a finish step, then 6 products for look-at and up and a final step
// that presents the beat; a move first forms the 3 products of the step
// vector, the 6 of the cross product and the position update. After reset
// the block first computes the initial vectors and is not ready meanwhile.
// Input is taken only while no result is pending and no register write is
// offered; the output register holds until taken, and the next input is
// accepted in the cycle after that at the earliest.
module spherical_camera_update_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [0:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic signed [18:0] yaw_step,
  input  logic signed [18:0] pitch_step,
  input  logic [2:0]         direction,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic signed [31:0] look_x,
  output logic signed [31:0] look_y,
  output logic signed [31:0] look_z,
  output logic signed [17:0] up_x,
  output logic signed [17:0] up_y,
  output logic signed [17:0] up_z
);

  localparam int AW     = scu_pkg::ANGLE_W;
  localparam int F      = scu_pkg::FRAC;
  localparam int UP_W_L = scu_pkg::UP_W;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_WRAP  = 4'd1;
  localparam logic [3:0] S_MOVD  = 4'd2;
  localparam logic [3:0] S_CROSS = 4'd3;
  localparam logic [3:0] S_POS   = 4'd4;
  localparam logic [3:0] S_CINIT = 4'd5;
  localparam logic [3:0] S_CITER = 4'd6;
  localparam logic [3:0] S_CDONE = 4'd7;
  localparam logic [3:0] S_LOOK  = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0] state;
  logic [4:0] step;
  logic       pass;      // 0 yaw, 1 pitch
  logic       dir_valid;
  logic [2:0] dir;

  // architectural state
  logic signed [31:0] pos [3];
  logic signed [31:0] look [3];
  logic signed [UP_W_L-1:0] upv [3];
  logic signed [AW-1:0] yaw, pitch;
  logic [23:0] radius;
  logic [16:0] speed;

  // scratch
  logic signed [31:0] dv [3];
  logic signed [F+1:0] sy, cy, sp, cp;
  logic signed [31:0] rc;

  // cordic registers
  logic signed [33:0] cx, cyr, cz;
  logic               flip;

  // shared multiply unit: 34x34 signed product, rounded half up by F bits
  logic signed [33:0] ma, mb;
  logic signed [67:0] prod;
  logic signed [67:0] prod_r;
  assign prod   = ma * mb;
  assign prod_r = (prod + 68'(64'sd1 <<< (F - 1))) >>> F;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    if (v > 68'sd2147483647) sat32 = 32'sh7fffffff;
    else if (v < -68'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction

  function automatic logic signed [AW-1:0] wrap(input logic signed [AW:0] a);
    logic signed [AW:0] p;
    p = (AW+1)'(scu_pkg::PI_F);
    if (a > p) wrap = AW'(a - 2 * p);
    else if (a < -p) wrap = AW'(a + 2 * p);
    else wrap = a[AW-1:0];
  endfunction

  function automatic logic signed [F+1:0] cord_out(input logic signed [33:0] v);
    logic signed [33:0] r;
    r = (v + 34'(64'sd1 <<< (scu_pkg::WORK - F - 1))) >>> (scu_pkg::WORK - F);
    if (r > 34'sd65536) cord_out = 18'sd65536;
    else if (r < -34'sd65536) cord_out = -18'sd65536;
    else cord_out = r[F+1:0];
  endfunction

  // operand select for the multiply unit
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      S_MOVD: begin
        ma = 34'(signed'({1'b0, speed}));
        mb = 34'(look[step[1:0]]) - 34'(pos[step[1:0]]);
      end
      S_CROSS: begin
        // step 2k: first product, 2k+1: second product of component k
        unique case (step)
          5'd0: begin ma = 34'(dv[1]); mb = 34'(upv[2]); end
          5'd1: begin ma = 34'(dv[2]); mb = 34'(upv[1]); end
          5'd2: begin ma = 34'(dv[2]); mb = 34'(upv[0]); end
          5'd3: begin ma = 34'(dv[0]); mb = 34'(upv[2]); end
          5'd4: begin ma = 34'(dv[0]); mb = 34'(upv[1]); end
          default: begin ma = 34'(dv[1]); mb = 34'(upv[0]); end
        endcase
      end
      S_LOOK: begin
        unique case (step)
          5'd0: begin ma = 34'(signed'({1'b0, radius})); mb = 34'(cp); end
          5'd1: begin ma = 34'(rc); mb = 34'(cy); end
          5'd2: begin ma = 34'(signed'({1'b0, radius})); mb = 34'(sp); end
          5'd3: begin ma = 34'(rc); mb = 34'(sy); end
          5'd4: begin ma = 34'(sp); mb = 34'(cy); end
          default: begin ma = 34'(sp); mb = 34'(sy); end
        endcase
      end
      default: ;
    endcase
  end

  // cordic step values
  logic signed [33:0] xs, ys, zin;
  logic signed [AW-1:0] ang;
  assign xs  = cx >>> step;
  assign ys  = cyr >>> step;
  assign ang = pass ? pitch : yaw;
  assign zin = 34'(ang) <<< (scu_pkg::WORK - F);

  // a register write offered in idle takes the cycle before an input beat
  assign cfg_ready = (state == S_IDLE);
  assign in_ready  = (state == S_IDLE) && !out_valid && !cfg_valid;

  // cross product component held between its two products
  logic signed [67:0] cprod;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CINIT;
      step      <= '0;
      pass      <= 1'b0;
      out_valid <= 1'b0;
      radius    <= 24'd2621440;
      speed     <= 17'd655;
      pos[0]    <= 32'sd2621440;
      pos[1]    <= 32'sd1310720;
      pos[2]    <= '0;
      yaw       <= '0;
      pitch     <= scu_pkg::SIXTH_F;
      dir       <= '0;
      dir_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            if (cfg_index == scu_pkg::REG_RADIUS) radius <= cfg_data;
            else speed <= cfg_data[16:0];
          end else if (in_valid && !out_valid) begin
            dir     <= direction;
            step    <= '0;
            if (kind) state <= S_MOVD;
            else begin
              yaw   <= wrap((AW+1)'(yaw) + (AW+1)'(yaw_step));
              pitch <= wrap((AW+1)'(pitch) + (AW+1)'(pitch_step));
              state <= S_CINIT;
              pass  <= 1'b0;
            end
          end
        end
        S_WRAP: state <= S_CINIT;
        S_MOVD: begin
          dv[step[1:0]] <= sat32(prod_r);
          if (step == 5'd2) begin step <= '0; state <= S_CROSS; end
          else step <= step + 5'd1;
        end
        S_CROSS: begin
          if (!step[0]) cprod <= prod;
          // one component of d x up, rounded once
          if (step[0]) begin
            unique case (step[2:1])
              2'd0: cx  <= 34'((cprod - prod + 68'(64'sd1 <<< (F-1))) >>> F);
              2'd1: cyr <= 34'((cprod - prod + 68'(64'sd1 <<< (F-1))) >>> F);
              default: cz <= 34'((cprod - prod + 68'(64'sd1 <<< (F-1))) >>> F);
            endcase
          end
          if (step == 5'd5) begin step <= '0; state <= S_POS; end
          else step <= step + 5'd1;
        end
        S_POS: begin
          for (int k = 0; k < 3; k++) begin
            logic signed [33:0] c;
            c = (k == 0) ? cx : ((k == 1) ? cyr : cz);
            unique case (dir)
              scu_pkg::DIR_FWD:   pos[k] <= sat32(68'(pos[k]) + 68'(dv[k]));
              scu_pkg::DIR_BACK:  pos[k] <= sat32(68'(pos[k]) - 68'(dv[k]));
              scu_pkg::DIR_LEFT:  pos[k] <= sat32(68'(pos[k]) - 68'(c));
              scu_pkg::DIR_RIGHT: pos[k] <= sat32(68'(pos[k]) + 68'(c));
              default: ;
            endcase
          end
          pass  <= 1'b0;
          state <= S_CINIT;
        end
        S_CINIT: begin
          // fold into [-pi/2, pi/2]
          cx   <= scu_pkg::GAIN_W;
          cyr  <= '0;
          step <= '0;
          if (zin > scu_pkg::HALF_PI_W) begin
            cz <= zin - scu_pkg::PI_W; flip <= 1'b1;
          end else if (zin < -scu_pkg::HALF_PI_W) begin
            cz <= zin + scu_pkg::PI_W; flip <= 1'b1;
          end else begin
            cz <= zin; flip <= 1'b0;
          end
          state <= S_CITER;
        end
        S_CITER: begin
          if (!cz[33]) begin
            cx  <= cx - ys;
            cyr <= cyr + xs;
            cz  <= cz - scu_pkg::atan_at(step);
          end else begin
            cx  <= cx + ys;
            cyr <= cyr - xs;
            cz  <= cz + scu_pkg::atan_at(step);
          end
          if (step == 5'(scu_pkg::ITERS - 1)) state <= S_CDONE;
          else step <= step + 5'd1;
        end
        S_CDONE: begin
          if (!pass) begin
            cy <= cord_out(flip ? -cx : cx);
            sy <= cord_out(flip ? -cyr : cyr);
            pass  <= 1'b1;
            state <= S_CINIT;
          end else begin
            cp <= cord_out(flip ? -cx : cx);
            sp <= cord_out(flip ? -cyr : cyr);
            step  <= '0;
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          unique case (step)
            5'd0: rc <= prod_r[31:0];
            5'd1: look[0] <= sat32(68'(pos[0]) - prod_r);
            5'd2: look[1] <= sat32(68'(pos[1]) - prod_r);
            5'd3: look[2] <= sat32(68'(pos[2]) - prod_r);
            5'd4: upv[0] <= UP_W_L'(-prod_r);
            default: begin
              upv[2] <= UP_W_L'(-prod_r);
              upv[1] <= cp;
            end
          endcase
          if (step == 5'd5) state <= S_OUT;
          else step <= step + 5'd1;
        end
        S_OUT: begin
          // the reset pass produces no beat
          if (dir_valid) out_valid <= 1'b1;
          dir_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign pos_x  = pos[0];
  assign pos_y  = pos[1];
  assign pos_z  = pos[2];
  assign look_x = look[0];
  assign look_y = look[1];
  assign look_z = look[2];
  assign up_x   = upv[0];
  assign up_y   = upv[1];
  assign up_z   = upv[2];

endmodule
